@@ rtl/core/lli_pkg.sv @@
package lli_pkg;

   localparam int CoordW = 32;
   localparam int FracW  = 16;
   localparam int DiffW  = CoordW + 1;
   localparam int ProdW  = 2 * DiffW;
   localparam int NdW    = ProdW + 1;
   localparam int ThrW   = 32;
   localparam int PxW    = CoordW + DiffW;
   localparam int MW     = PxW - FracW;
   localparam int SumW   = MW + 1;
   localparam int FrontN = 5;
   localparam int BackN  = 4;
   localparam int StageN = FrontN + CoordW + BackN;

   localparam logic [ThrW-1:0] ThrReset = 32'd4295;
   localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
   localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
   localparam logic signed [CoordW-1:0] FixOne   = CoordW'(1) << FracW;

   typedef struct packed {
      logic signed [CoordW-1:0] x1;
      logic signed [CoordW-1:0] y1;
      logic signed [CoordW-1:0] z;
      logic signed [DiffW-1:0]  fx;
      logic signed [DiffW-1:0]  fy;
   } side_type;

   typedef struct packed {
      logic [NdW-1:0]    r;
      logic [CoordW-1:0] low;
      logic [CoordW-1:0] q;
      logic [NdW-1:0]    d;
   } div_type;

   typedef struct packed {
      logic neg;
      logic par;
      logic ovf;
   } ctl_type;

   typedef struct packed {
      logic signed [CoordW-1:0] value;
      logic                     clip;
   } sat_type;

   function automatic sat_type sat_sum(input logic signed [SumW-1:0] v);
      sat_type                  res;
      logic [SumW-CoordW:0]     upper;
      upper = v[SumW-1:CoordW-1];
      if ((&upper) || !(|upper)) begin
         res.value = v[CoordW-1:0];
         res.clip  = 1'b0;
      end else begin
         res.value = v[SumW-1] ? CoordMin : CoordMax;
         res.clip  = 1'b1;
      end
      return res;
   endfunction

endpackage

@@ rtl/core/line_line_intersection.sv @@
// Intersection of the line through p1,p2 with the line through p3,p4, signed Q16.16.
// Fully pipelined: one beat is taken every cycle while req_stall is low, and each result
// appears once its beat has passed the 32-cell restoring divider chain
// (one quotient bit per cell), the five stages ahead of it and the four behind it.
// Back-pressure on rsp_stall only stalls stages that hold a beat, so bubbles in the
// pipe still absorb new beats while a result waits. The parallel threshold is
// compared against |den| at product scale (Q32.32); den equal to zero is always
// parallel, and then p2 is returned with line_factor one. Write csr_ only while idle.
module line_line_intersection
   import lli_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [ThrW-1:0]          csr_write_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [CoordW-1:0] req_p1_x,
   input  logic signed [CoordW-1:0] req_p1_y,
   input  logic signed [CoordW-1:0] req_p1_z,
   input  logic signed [CoordW-1:0] req_p2_x,
   input  logic signed [CoordW-1:0] req_p2_y,
   input  logic signed [CoordW-1:0] req_p3_x,
   input  logic signed [CoordW-1:0] req_p3_y,
   input  logic signed [CoordW-1:0] req_p4_x,
   input  logic signed [CoordW-1:0] req_p4_y,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [CoordW-1:0] rsp_hit_x,
   output logic signed [CoordW-1:0] rsp_hit_y,
   output logic signed [CoordW-1:0] rsp_hit_z,
   output logic signed [CoordW-1:0] rsp_line_factor,
   output logic                     rsp_parallel_flag,
   output logic                     rsp_saturated_flag
);

   logic [ThrW-1:0]   thr_ff, thr_in;
   logic [StageN-1:0] vld_ff, vld_in;
   logic [StageN-1:0] open;

   div_type           cell_div  [CoordW+1];
   ctl_type           cell_ctl  [CoordW+1];
   side_type          cell_side [CoordW+1];

   // a stage may take a new beat when it is empty or its successor moves
   genvar k;
   generate
      for (k = 0; k < StageN; k++) begin : g_open
         if (k == StageN - 1) begin : g_last
            assign open[k] = !vld_ff[k] || !rsp_stall;
         end else begin : g_mid
            assign open[k] = !vld_ff[k] || open[k+1];
         end
      end
   endgenerate

   always_comb begin
      thr_in    = csr_write_enable ? csr_write_data : thr_ff;
      vld_in[0] = open[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < StageN; i++) begin
         vld_in[i] = open[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThrReset;
         vld_ff <= '0;
      end else begin
         thr_ff <= thr_in;
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !open[0];
   assign rsp_valid = vld_ff[StageN-1];

   lli_front u_front (
      .clock    (clock),
      .load     (open[FrontN-1:0]),
      .p1_x     (req_p1_x),
      .p1_y     (req_p1_y),
      .p1_z     (req_p1_z),
      .p2_x     (req_p2_x),
      .p2_y     (req_p2_y),
      .p3_x     (req_p3_x),
      .p3_y     (req_p3_y),
      .p4_x     (req_p4_x),
      .p4_y     (req_p4_y),
      .thr      (thr_ff),
      .div_out  (cell_div[0]),
      .ctl_out  (cell_ctl[0]),
      .side_out (cell_side[0])
   );

   generate
      for (k = 0; k < CoordW; k++) begin : g_cell
         lli_div_cell u_cell (
            .clock    (clock),
            .load     (open[FrontN+k]),
            .src_div  (cell_div[k]),
            .src_ctl  (cell_ctl[k]),
            .src_side (cell_side[k]),
            .dst_div  (cell_div[k+1]),
            .dst_ctl  (cell_ctl[k+1]),
            .dst_side (cell_side[k+1])
         );
      end
   endgenerate

   lli_back u_back (
      .clock          (clock),
      .load           (open[StageN-1:FrontN+CoordW]),
      .quo            (cell_div[CoordW].q),
      .ctl            (cell_ctl[CoordW]),
      .side           (cell_side[CoordW]),
      .hit_x          (rsp_hit_x),
      .hit_y          (rsp_hit_y),
      .hit_z          (rsp_hit_z),
      .line_factor    (rsp_line_factor),
      .parallel_flag  (rsp_parallel_flag),
      .saturated_flag (rsp_saturated_flag)
   );

endmodule

@@ rtl/core/lli_front.sv @@
module lli_front
   import lli_pkg::*;
(
   input  logic                     clock,
   input  logic [FrontN-1:0]        load,
   input  logic signed [CoordW-1:0] p1_x,
   input  logic signed [CoordW-1:0] p1_y,
   input  logic signed [CoordW-1:0] p1_z,
   input  logic signed [CoordW-1:0] p2_x,
   input  logic signed [CoordW-1:0] p2_y,
   input  logic signed [CoordW-1:0] p3_x,
   input  logic signed [CoordW-1:0] p3_y,
   input  logic signed [CoordW-1:0] p4_x,
   input  logic signed [CoordW-1:0] p4_y,
   input  logic [ThrW-1:0]          thr,
   output div_type                  div_out,
   output ctl_type                  ctl_out,
   output side_type                 side_out
);

   logic signed [DiffW-1:0] ex_ff, ey_ff, gx_ff, gy_ff;
   logic signed [DiffW-1:0] ex_in, ey_in, gx_in, gy_in;
   side_type                side_a_ff, side_a_in;

   logic signed [ProdW-1:0] exgy_ff, eygx_ff, eyfx_ff, exfy_ff;
   logic signed [ProdW-1:0] exgy_in, eygx_in, eyfx_in, exfy_in;
   side_type                side_b_ff;

   logic signed [NdW-1:0]   num_ff, den_ff, num_in, den_in;
   side_type                side_c_ff;

   logic [NdW-1:0]          an_ff, ad_ff, an_in, ad_in;
   logic                    neg_d_ff, neg_d_in;
   side_type                side_d_ff;

   div_type                 div_ff, div_in;
   ctl_type                 ctl_ff, ctl_in;
   side_type                side_e_ff;

   // stage A: differences
   always_comb begin
      ex_in = $signed({p4_x[CoordW-1], p4_x}) - $signed({p3_x[CoordW-1], p3_x});
      ey_in = $signed({p4_y[CoordW-1], p4_y}) - $signed({p3_y[CoordW-1], p3_y});
      gx_in = $signed({p1_x[CoordW-1], p1_x}) - $signed({p3_x[CoordW-1], p3_x});
      gy_in = $signed({p1_y[CoordW-1], p1_y}) - $signed({p3_y[CoordW-1], p3_y});
      side_a_in.x1 = p1_x;
      side_a_in.y1 = p1_y;
      side_a_in.z  = p1_z;
      side_a_in.fx = $signed({p2_x[CoordW-1], p2_x}) - $signed({p1_x[CoordW-1], p1_x});
      side_a_in.fy = $signed({p2_y[CoordW-1], p2_y}) - $signed({p1_y[CoordW-1], p1_y});
   end

   // stage B: cross products
   always_comb begin
      exgy_in = ex_ff * gy_ff;
      eygx_in = ey_ff * gx_ff;
      eyfx_in = ey_ff * $signed(side_a_ff.fx);
      exfy_in = ex_ff * $signed(side_a_ff.fy);
   end

   // stage C: numerator and denominator
   always_comb begin
      num_in = $signed({exgy_ff[ProdW-1], exgy_ff}) - $signed({eygx_ff[ProdW-1], eygx_ff});
      den_in = $signed({eyfx_ff[ProdW-1], eyfx_ff}) - $signed({exfy_ff[ProdW-1], exfy_ff});
   end

   // stage D: magnitudes
   always_comb begin
      an_in    = num_ff[NdW-1] ? -num_ff : num_ff;
      ad_in    = den_ff[NdW-1] ? -den_ff : den_ff;
      neg_d_in = num_ff[NdW-1] ^ den_ff[NdW-1];
   end

   // stage E: parallel test, overflow test, divider seed
   always_comb begin
      ctl_in.neg = neg_d_ff;
      ctl_in.par = (ad_ff < {{(NdW-ThrW){1'b0}}, thr}) || (ad_ff == '0);
      ctl_in.ovf = (an_ff >> FracW) >= ad_ff;
      div_in.r   = an_ff >> FracW;
      div_in.low = {an_ff[FracW-1:0], {(CoordW-FracW){1'b0}}};
      div_in.q   = '0;
      div_in.d   = ad_ff;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         ex_ff     <= ex_in;
         ey_ff     <= ey_in;
         gx_ff     <= gx_in;
         gy_ff     <= gy_in;
         side_a_ff <= side_a_in;
      end
      if (load[1]) begin
         exgy_ff   <= exgy_in;
         eygx_ff   <= eygx_in;
         eyfx_ff   <= eyfx_in;
         exfy_ff   <= exfy_in;
         side_b_ff <= side_a_ff;
      end
      if (load[2]) begin
         num_ff    <= num_in;
         den_ff    <= den_in;
         side_c_ff <= side_b_ff;
      end
      if (load[3]) begin
         an_ff     <= an_in;
         ad_ff     <= ad_in;
         neg_d_ff  <= neg_d_in;
         side_d_ff <= side_c_ff;
      end
      if (load[4]) begin
         div_ff    <= div_in;
         ctl_ff    <= ctl_in;
         side_e_ff <= side_d_ff;
      end
   end

   assign div_out  = div_ff;
   assign ctl_out  = ctl_ff;
   assign side_out = side_e_ff;

endmodule

@@ rtl/core/lli_div_cell.sv @@
module lli_div_cell
   import lli_pkg::*;
(
   input  logic     clock,
   input  logic     load,
   input  div_type  src_div,
   input  ctl_type  src_ctl,
   input  side_type src_side,
   output div_type  dst_div,
   output ctl_type  dst_ctl,
   output side_type dst_side
);

   logic [NdW:0] trial;
   logic [NdW:0] diff;
   logic         qbit;
   div_type      div_ff, div_in;
   ctl_type      ctl_ff;
   side_type     side_ff;

   // one restoring step: bring in the next numerator bit, subtract when it fits
   always_comb begin
      trial      = {src_div.r, src_div.low[CoordW-1]};
      diff       = trial - {1'b0, src_div.d};
      qbit       = !diff[NdW];
      div_in.r   = qbit ? diff[NdW-1:0] : trial[NdW-1:0];
      div_in.low = src_div.low << 1;
      div_in.q   = {src_div.q[CoordW-2:0], qbit};
      div_in.d   = src_div.d;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         div_ff  <= div_in;
         ctl_ff  <= src_ctl;
         side_ff <= src_side;
      end
   end

   assign dst_div  = div_ff;
   assign dst_ctl  = ctl_ff;
   assign dst_side = side_ff;

endmodule

@@ rtl/core/lli_back.sv @@
module lli_back
   import lli_pkg::*;
(
   input  logic                     clock,
   input  logic [BackN-1:0]         load,
   input  logic [CoordW-1:0]        quo,
   input  ctl_type                  ctl,
   input  side_type                 side,
   output logic signed [CoordW-1:0] hit_x,
   output logic signed [CoordW-1:0] hit_y,
   output logic signed [CoordW-1:0] hit_z,
   output logic signed [CoordW-1:0] line_factor,
   output logic                     parallel_flag,
   output logic                     saturated_flag
);

   logic signed [CoordW-1:0] t_ff, t_in;
   logic                     clip_t_ff, clip_t_in;
   logic                     par_t_ff;
   side_type                 side_t_ff;

   logic signed [PxW-1:0]    px_ff, py_ff, px_in, py_in;
   logic signed [CoordW-1:0] t_m_ff, x1_m_ff, y1_m_ff, z_m_ff;
   logic                     clip_m_ff, par_m_ff;

   logic signed [PxW-1:0]    pxb, pyb;
   logic signed [MW-1:0]     mx_ff, my_ff, mx_in, my_in;
   logic signed [CoordW-1:0] t_r_ff, x1_r_ff, y1_r_ff, z_r_ff;
   logic                     clip_r_ff, par_r_ff;

   logic signed [SumW-1:0]   sx, sy;
   sat_type                  satx, saty;
   logic signed [CoordW-1:0] hit_x_ff, hit_y_ff, hit_z_ff, factor_ff;
   logic                     par_ff, sat_ff;

   // stage T: signed, clipped line factor
   always_comb begin
      t_in      = $signed(quo);
      clip_t_in = 1'b0;
      priority if (ctl.par) begin
         t_in = FixOne;
      end else if (ctl.ovf) begin
         t_in      = ctl.neg ? CoordMin : CoordMax;
         clip_t_in = 1'b1;
      end else if (!ctl.neg) begin
         if (quo[CoordW-1]) begin
            t_in      = CoordMax;
            clip_t_in = 1'b1;
         end
      end else begin
         if (quo[CoordW-1] && (|quo[CoordW-2:0])) begin
            t_in      = CoordMin;
            clip_t_in = 1'b1;
         end else begin
            t_in = -$signed(quo);
         end
      end
   end

   // stage M: factor times direction
   always_comb begin
      px_in = t_ff * $signed(side_t_ff.fx);
      py_in = t_ff * $signed(side_t_ff.fy);
   end

   // stage R: drop fraction, truncating toward zero
   always_comb begin
      pxb   = px_ff + $signed({{(PxW-FracW){1'b0}}, {FracW{px_ff[PxW-1]}}});
      pyb   = py_ff + $signed({{(PxW-FracW){1'b0}}, {FracW{py_ff[PxW-1]}}});
      mx_in = pxb[PxW-1:FracW];
      my_in = pyb[PxW-1:FracW];
   end

   // stage O: add start point and clip
   always_comb begin
      sx   = $signed({mx_ff[MW-1], mx_ff})
             + $signed({{(SumW-CoordW){x1_r_ff[CoordW-1]}}, x1_r_ff});
      sy   = $signed({my_ff[MW-1], my_ff})
             + $signed({{(SumW-CoordW){y1_r_ff[CoordW-1]}}, y1_r_ff});
      satx = sat_sum(sx);
      saty = sat_sum(sy);
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         t_ff      <= t_in;
         clip_t_ff <= clip_t_in;
         par_t_ff  <= ctl.par;
         side_t_ff <= side;
      end
      if (load[1]) begin
         px_ff     <= px_in;
         py_ff     <= py_in;
         t_m_ff    <= t_ff;
         x1_m_ff   <= side_t_ff.x1;
         y1_m_ff   <= side_t_ff.y1;
         z_m_ff    <= side_t_ff.z;
         clip_m_ff <= clip_t_ff;
         par_m_ff  <= par_t_ff;
      end
      if (load[2]) begin
         mx_ff     <= mx_in;
         my_ff     <= my_in;
         t_r_ff    <= t_m_ff;
         x1_r_ff   <= x1_m_ff;
         y1_r_ff   <= y1_m_ff;
         z_r_ff    <= z_m_ff;
         clip_r_ff <= clip_m_ff;
         par_r_ff  <= par_m_ff;
      end
      if (load[3]) begin
         hit_x_ff  <= satx.value;
         hit_y_ff  <= saty.value;
         hit_z_ff  <= z_r_ff;
         factor_ff <= t_r_ff;
         par_ff    <= par_r_ff;
         sat_ff    <= clip_r_ff | satx.clip | saty.clip;
      end
   end

   assign hit_x          = hit_x_ff;
   assign hit_y          = hit_y_ff;
   assign hit_z          = hit_z_ff;
   assign line_factor    = factor_ff;
   assign parallel_flag  = par_ff;
   assign saturated_flag = sat_ff;

endmodule

@@ dv/tb_line_line_intersection.sv @@
`timescale 1ns / 100ps

module tb_line_line_intersection;
   import lli_pkg::*;

   localparam int STUCK_LIMIT = 5000;
   localparam int RANDOM_PER_PHASE = 260;
   localparam int TABLE_ROWS = 18;

   typedef logic signed [127:0] wide_t;

   localparam wide_t WIDE_MAX = 128'sh7FFF_FFFF;
   localparam wide_t WIDE_MIN = -128'sh8000_0000;

   typedef struct packed {
      logic signed [CoordW-1:0] p1_x;
      logic signed [CoordW-1:0] p1_y;
      logic signed [CoordW-1:0] p1_z;
      logic signed [CoordW-1:0] p2_x;
      logic signed [CoordW-1:0] p2_y;
      logic signed [CoordW-1:0] p3_x;
      logic signed [CoordW-1:0] p3_y;
      logic signed [CoordW-1:0] p4_x;
      logic signed [CoordW-1:0] p4_y;
   } query_t;

   typedef struct packed {
      logic signed [CoordW-1:0] hit_x;
      logic signed [CoordW-1:0] hit_y;
      logic signed [CoordW-1:0] hit_z;
      logic signed [CoordW-1:0] line_factor;
      logic                     parallel_flag;
      logic                     saturated_flag;
   } hit_t;

   typedef struct packed {
      logic signed [CoordW-1:0] value;
      logic                     clip;
   } clip_t;

   typedef struct packed {
      logic [ThrW-1:0] thr;
      query_t          q;
      logic            typed;
      hit_t            want;
   } stim_row_t;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_e;

   typedef enum int {
      SHAPE_RAW,
      SHAPE_MODERATE,
      SHAPE_TINY,
      SHAPE_PARALLEL,
      SHAPE_NEAR_PARALLEL,
      SHAPE_DEGENERATE,
      SHAPE_EXTREME
   } shape_e;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [ThrW-1:0]   csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   query_t            cur_query = '0;
   logic              cur_typed = 1'b0;
   hit_t              cur_want = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [CoordW-1:0] rsp_hit_x;
   logic signed [CoordW-1:0] rsp_hit_y;
   logic signed [CoordW-1:0] rsp_hit_z;
   logic signed [CoordW-1:0] rsp_line_factor;
   logic              rsp_parallel_flag;
   logic              rsp_saturated_flag;

   hit_t              pending_hits[$];
   hit_t              got_hit;
   hit_t              want_hit;
   logic [ThrW-1:0]   thr_model = ThrReset;
   logic [ThrW-1:0]   thr_now = ThrReset;
   int                mismatch_count = 0;
   int                stuck_cycles = 0;
   int                burst_left = 0;
   stall_mode_e       stall_mode = STALL_NONE;
   int                mode_left = 0;
   int                stall_phase = 0;
   int                stall_period = 2;

   stim_row_t stim_table [TABLE_ROWS] = '{
      '{ThrReset, '{0, 0, 0, 0, 0, 0, 0, 0, 0},
        1'b1, '{0, 0, 0, FixOne, 1'b1, 1'b0}},
      '{ThrReset, '{CoordMax, CoordMin, CoordMin, CoordMax, CoordMin, 0, 0, FixOne, FixOne},
        1'b1, '{CoordMax, CoordMin, CoordMin, FixOne, 1'b1, 1'b0}},
      '{ThrReset, '{-FixOne, 0, FixOne, FixOne, 0, 0, -FixOne, 0, FixOne},
        1'b1, '{0, 0, FixOne, 32'sh0000_8000, 1'b0, 1'b0}},
      '{ThrReset, '{0, 0, CoordMax, 32'sh0000_8000, 0, CoordMax, CoordMin, CoordMax, CoordMax},
        1'b1, '{32'sh3FFF_FFFF, 0, CoordMax, CoordMax, 1'b0, 1'b1}},
      '{ThrReset, '{0, 0, -1, 1, 0, 0, 0, 0, 1},
        1'b1, '{1, 0, -1, FixOne, 1'b1, 1'b0}},
      '{ThrReset, '{0, 0, 0, 4294, 0, 0, 0, 0, 1},
        1'b1, '{4294, 0, 0, FixOne, 1'b1, 1'b0}},
      '{ThrReset, '{0, 0, 0, 4295, 0, 0, 0, 0, 1},
        1'b1, '{0, 0, 0, 0, 1'b0, 1'b0}},
      '{ThrReset, '{CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax,
                    CoordMax, CoordMax}, 1'b0, '{default: 0}},
      '{ThrReset, '{CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin,
                    CoordMin, CoordMin}, 1'b0, '{default: 0}},
      '{ThrReset, '{CoordMin, CoordMin, 32'sh5555_5555, CoordMax, CoordMax, CoordMin, CoordMax,
                    CoordMax, CoordMin}, 1'b0, '{default: 0}},
      '{ThrReset, '{0, 0, 7, FixOne, 0, -32'sh2_0000, -FixOne, -32'sh2_0000, FixOne},
        1'b0, '{default: 0}},
      '{ThrReset, '{32'sh4000_0000, 0, 32'hAAAA_AAAA, 32'sh4001_0000, 1, 0, 32'sh0010_0000,
                    FixOne, 32'sh0010_0000}, 1'b0, '{default: 0}},
      '{ThrReset, '{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555},
        1'b0, '{default: 0}},
      '{ThrReset, '{FixOne, 0, 0, 0, 0, 32'sh0000_8000, -FixOne, 32'sh0000_8000, FixOne},
        1'b0, '{default: 0}},
      '{32'd0, '{0, 0, 0, 0, 0, 0, 0, 0, 0},
        1'b1, '{0, 0, 0, FixOne, 1'b1, 1'b0}},
      '{32'd0, '{0, 0, 0, 1, 0, 0, 0, 0, 1},
        1'b1, '{0, 0, 0, 0, 1'b0, 1'b0}},
      '{32'hFFFF_FFFF, '{-FixOne, 0, 3, FixOne, 0, 0, -FixOne, 0, FixOne},
        1'b0, '{default: 0}},
      '{32'hFFFF_FFFF, '{0, 0, 0, 1, 0, 0, 0, 0, 1},
        1'b1, '{1, 0, 0, FixOne, 1'b1, 1'b0}}
   };

   line_line_intersection dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_p1_x           (cur_query.p1_x),
      .req_p1_y           (cur_query.p1_y),
      .req_p1_z           (cur_query.p1_z),
      .req_p2_x           (cur_query.p2_x),
      .req_p2_y           (cur_query.p2_y),
      .req_p3_x           (cur_query.p3_x),
      .req_p3_y           (cur_query.p3_y),
      .req_p4_x           (cur_query.p4_x),
      .req_p4_y           (cur_query.p4_y),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit_x          (rsp_hit_x),
      .rsp_hit_y          (rsp_hit_y),
      .rsp_hit_z          (rsp_hit_z),
      .rsp_line_factor    (rsp_line_factor),
      .rsp_parallel_flag  (rsp_parallel_flag),
      .rsp_saturated_flag (rsp_saturated_flag)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic clip_t clip_coord(input wide_t v);
      clip_t c;
      if (v > WIDE_MAX) begin
         c.value = CoordMax;
         c.clip  = 1'b1;
      end else if (v < WIDE_MIN) begin
         c.value = CoordMin;
         c.clip  = 1'b1;
      end else begin
         c.value = v[CoordW-1:0];
         c.clip  = 1'b0;
      end
      return c;
   endfunction

   // f*d scaled back to coordinate format, truncated toward zero
   function automatic wide_t offset_along(input wide_t f, input wide_t d);
      wide_t p;
      wide_t m;
      p = f * d;
      m = ((p < 0) ? -p : p) >>> FracW;
      return (p < 0) ? -m : m;
   endfunction

   function automatic hit_t intersect_lines(input query_t q, input logic [ThrW-1:0] thr);
      wide_t        x1, y1, x2, y2, x3, y3, x4, y4;
      wide_t        ex, ey, fx, fy, gx, gy, num, den, tw, f;
      logic [127:0] anum, aden, quo;
      clip_t        ts, hx, hy;
      hit_t         h;
      x1 = $signed(q.p1_x);
      y1 = $signed(q.p1_y);
      x2 = $signed(q.p2_x);
      y2 = $signed(q.p2_y);
      x3 = $signed(q.p3_x);
      y3 = $signed(q.p3_y);
      x4 = $signed(q.p4_x);
      y4 = $signed(q.p4_y);
      ex = x4 - x3;
      ey = y4 - y3;
      fx = x2 - x1;
      fy = y2 - y1;
      gx = x1 - x3;
      gy = y1 - y3;
      num = ex * gy - ey * gx;
      den = ey * fx - ex * fy;
      aden = (den < 0) ? -den : den;
      h.parallel_flag = (aden == '0) || (aden < {96'd0, thr});
      if (h.parallel_flag) begin
         tw = $signed(FixOne);
      end else begin
         anum = (num < 0) ? -num : num;
         quo = (anum << FracW) / aden;
         tw = quo;
         if ((num < 0) != (den < 0)) tw = -tw;
      end
      ts = clip_coord(tw);
      f = $signed(ts.value);
      hx = clip_coord(x1 + offset_along(f, fx));
      hy = clip_coord(y1 + offset_along(f, fy));
      h.hit_x = hx.value;
      h.hit_y = hy.value;
      h.hit_z = q.p1_z;
      h.line_factor = ts.value;
      h.saturated_flag = ts.clip | hx.clip | hy.clip;
      return h;
   endfunction

   function automatic logic signed [CoordW-1:0] spread(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic signed [CoordW-1:0] extreme_coord();
      case ($urandom_range(0, 5))
         0: return CoordMin;
         1: return CoordMax;
         2: return 0;
         3: return FixOne;
         4: return -FixOne;
         default: return $urandom;
      endcase
   endfunction

   function automatic query_t random_query();
      query_t q;
      shape_e shape;
      int     k;
      logic signed [CoordW-1:0] dx, dy;
      shape = shape_e'($urandom_range(0, 6));
      q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
      if (shape != SHAPE_RAW && shape != SHAPE_EXTREME) begin
         q.p1_x = spread(1 << 20);
         q.p1_y = spread(1 << 20);
         q.p2_x = spread(1 << 20);
         q.p2_y = spread(1 << 20);
         q.p3_x = spread(1 << 20);
         q.p3_y = spread(1 << 20);
         q.p4_x = spread(1 << 20);
         q.p4_y = spread(1 << 20);
      end
      case (shape)
         SHAPE_TINY: begin
            q.p1_x = spread(64);
            q.p1_y = spread(64);
            q.p2_x = spread(64);
            q.p2_y = spread(64);
            q.p3_x = spread(64);
            q.p3_y = spread(64);
            q.p4_x = spread(64);
            q.p4_y = spread(64);
         end
         SHAPE_PARALLEL, SHAPE_NEAR_PARALLEL: begin
            dx = spread(4096);
            dy = spread(4096);
            k = spread(3);
            q.p2_x = q.p1_x + dx;
            q.p2_y = q.p1_y + dy;
            q.p4_x = q.p3_x + k * dx;
            q.p4_y = q.p3_y + k * dy;
            if (shape == SHAPE_NEAR_PARALLEL) begin
               q.p4_x = q.p4_x + spread(2);
               q.p4_y = q.p4_y + spread(2);
            end
         end
         SHAPE_DEGENERATE: begin
            if ($urandom_range(0, 1)) begin
               q.p2_x = q.p1_x;
               q.p2_y = q.p1_y;
            end else begin
               q.p4_x = q.p3_x;
               q.p4_y = q.p3_y;
            end
         end
         SHAPE_EXTREME: begin
            q.p1_x = extreme_coord();
            q.p1_y = extreme_coord();
            q.p2_x = extreme_coord();
            q.p2_y = extreme_coord();
            q.p3_x = extreme_coord();
            q.p3_y = extreme_coord();
            q.p4_x = extreme_coord();
            q.p4_y = extreme_coord();
         end
         default: ;
      endcase
      return q;
   endfunction

   task automatic check_field(input string name, input logic signed [CoordW-1:0] want,
                              input logic signed [CoordW-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d (%h), got %0d (%h)", $time, name, want, want, got, got);
         mismatch_count++;
      end
   endtask

   // scoreboard: predict on each accepted query beat, compare each accepted result beat
   always @(posedge clock) begin
      if (reset) begin
         thr_model = ThrReset;
         stuck_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_hits.push_back(cur_typed ? cur_want : intersect_lines(cur_query, thr_model));
         end
         if (rsp_valid && !rsp_stall) begin
            got_hit = '{rsp_hit_x, rsp_hit_y, rsp_hit_z, rsp_line_factor, rsp_parallel_flag,
                        rsp_saturated_flag};
            if (pending_hits.size() == 0) begin
               $display("%0t: result beat with nothing pending, got %p", $time, got_hit);
               mismatch_count++;
            end else begin
               want_hit = pending_hits.pop_front();
               check_field("hit_x", want_hit.hit_x, got_hit.hit_x);
               check_field("hit_y", want_hit.hit_y, got_hit.hit_y);
               check_field("hit_z", want_hit.hit_z, got_hit.hit_z);
               check_field("line_factor", want_hit.line_factor, got_hit.line_factor);
               check_field("parallel_flag", want_hit.parallel_flag, got_hit.parallel_flag);
               check_field("saturated_flag", want_hit.saturated_flag, got_hit.saturated_flag);
            end
         end
         if (csr_write_enable) thr_model = csr_write_data;
         stuck_cycles <= ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) ?
                         0 : stuck_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_e'($urandom_range(0, 3));
         mode_left = $urandom_range(40, 400);
         stall_period = $urandom_range(2, 24);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_phase % stall_period) < (stall_period / 2);
      endcase
   end

   task automatic send_query(input query_t q, input logic typed, input hit_t want);
      int gap;
      @(negedge clock);
      cur_query <= q;
      cur_typed <= typed;
      cur_want <= want;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 64);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain_hits();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(negedge clock);
   endtask

   task automatic set_threshold(input logic [ThrW-1:0] value);
      drain_hits();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      thr_now = value;
   endtask

   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("%0t: watchdog, no beat accepted for %0d cycles", $time, STUCK_LIMIT);
      $display("FAIL line_line_intersection");
      $finish;
   end

   initial begin
      logic [ThrW-1:0] phase_thr [5];
      phase_thr = '{32'd0, 32'hFFFF_FFFF, $urandom, $urandom_range(1, 32'h0010_0000), ThrReset};
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].thr != thr_now) set_threshold(stim_table[i].thr);
         send_query(stim_table[i].q, stim_table[i].typed, stim_table[i].want);
      end

      foreach (phase_thr[p]) begin
         set_threshold(phase_thr[p]);
         repeat (RANDOM_PER_PHASE) send_query(random_query(), 1'b0, '0);
      end

      drain_hits();
      repeat (60) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS line_line_intersection");
      end else begin
         $display("FAIL line_line_intersection");
      end
      $finish;
   end

endmodule
